FILE: rtl/core/hms_pkg.sv
// Shared types, codes and wrap helpers for the hours/minutes/seconds countdown timer.
`timescale 1ns / 1ps

package hms_pkg;

  localparam int unsigned HourW   = 5;
  localparam int unsigned MinSecW = 6;
  localparam int unsigned SecsW   = 17;
  localparam int unsigned StepW   = 6;

  localparam logic [SecsW-1:0] ThresholdReset = SecsW'(10);
  localparam logic [SecsW-1:0] SecPerHour     = SecsW'(3600);
  localparam logic [SecsW-1:0] SecPerMin      = SecsW'(60);

  localparam logic [MinSecW-1:0] MinSecMax = MinSecW'(59);

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_TOGGLE = 2'd1,
    KIND_RESET  = 2'd2,
    KIND_ADJUST = 2'd3
  } kind_t;

  localparam logic [1:0] SEG_HOURS   = 2'd0;
  localparam logic [1:0] SEG_MINUTES = 2'd1;
  localparam logic [1:0] SEG_SECONDS = 2'd2;
  localparam logic [1:0] SEG_NONE    = 2'd3;

  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  typedef struct packed {
    kind_t            kind;
    logic [1:0]       segment;
    logic             direction;
    logic [StepW-1:0] step;
  } evt_t;

  typedef struct packed {
    logic [HourW-1:0]   hours;
    logic [MinSecW-1:0] minutes;
    logic [MinSecW-1:0] seconds;
    logic               running;
    logic               active;
    logic               expiring;
  } res_t;

  // Hours wrap modulo 24; the step (0..63) is first reduced modulo 24.
  function automatic logic [HourW-1:0] wrap_hours(input logic [HourW-1:0] v,
                                                  input logic [StepW-1:0] step,
                                                  input logic down);
    logic [StepW-1:0] s;
    logic [StepW-1:0] t;
    if (step >= StepW'(48)) begin
      s = step - StepW'(48);
    end else if (step >= StepW'(24)) begin
      s = step - StepW'(24);
    end else begin
      s = step;
    end
    if (down == DIR_DOWN) begin
      t = StepW'(v) + StepW'(24) - s;
    end else begin
      t = StepW'(v) + s;
    end
    if (t >= StepW'(24)) begin
      t = t - StepW'(24);
    end
    return t[HourW-1:0];
  endfunction

  // Minutes and seconds wrap modulo 60.
  function automatic logic [MinSecW-1:0] wrap_minsec(input logic [MinSecW-1:0] v,
                                                     input logic [StepW-1:0] step,
                                                     input logic down);
    logic [StepW-1:0]   s;
    logic [MinSecW:0]   t;
    s = (step >= StepW'(60)) ? step - StepW'(60) : step;
    if (down == DIR_DOWN) begin
      t = (MinSecW+1)'(v) + (MinSecW+1)'(60) - (MinSecW+1)'(s);
    end else begin
      t = (MinSecW+1)'(v) + (MinSecW+1)'(s);
    end
    if (t >= (MinSecW+1)'(60)) begin
      t = t - (MinSecW+1)'(60);
    end
    return t[MinSecW-1:0];
  endfunction

endpackage

FILE: rtl/core/hms_in_reg.sv
// Input register stage holding one request for the timer core.
`timescale 1ns / 1ps

module hms_in_reg
  import hms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic evt_valid,
  output logic evt_stall,
  input  evt_t evt_in,
  input  logic advance,
  output logic s1_valid,
  output evt_t s1_evt
);

  // The stage holds only while its request cannot move on to the core.
  assign evt_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!evt_stall) begin
      s1_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      s1_evt <= evt_in;
    end
  end

endmodule

FILE: rtl/core/hms_core.sv
// Timer state update and result register.
`timescale 1ns / 1ps

module hms_core
  import hms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s1_valid,
  input  evt_t             s1_evt,
  input  logic [SecsW-1:0] threshold,
  input  logic             res_stall,
  output logic             advance,
  output logic             res_valid,
  output res_t             res
);

  // Display fields.
  logic [HourW-1:0]   disp_h, disp_h_next;
  logic [MinSecW-1:0] disp_m, disp_m_next;
  logic [MinSecW-1:0] disp_s, disp_s_next;
  // Remaining time, kept both in seconds and split, so a tick needs no division.
  logic [HourW-1:0]   rem_h, rem_h_next;
  logic [MinSecW-1:0] rem_m, rem_m_next;
  logic [MinSecW-1:0] rem_s, rem_s_next;
  logic [SecsW-1:0]   rem_secs, rem_secs_next;
  logic               run, run_next;
  logic               loaded, loaded_next;

  logic               upd;
  logic [SecsW-1:0]   load_secs;

  assign advance = !res_valid || !res_stall;
  assign upd     = s1_valid && advance;

  assign load_secs = SecsW'(disp_h) * SecPerHour + SecsW'(disp_m) * SecPerMin
                   + SecsW'(disp_s);

  always_comb begin
    disp_h_next   = disp_h;
    disp_m_next   = disp_m;
    disp_s_next   = disp_s;
    rem_h_next    = rem_h;
    rem_m_next    = rem_m;
    rem_s_next    = rem_s;
    rem_secs_next = rem_secs;
    run_next      = run;
    loaded_next   = loaded;
    unique case (s1_evt.kind)
      KIND_TICK: begin
        if (run) begin
          if (rem_secs == '0) begin
            // One tick past zero clears the timer.
            run_next    = 1'b0;
            loaded_next = 1'b0;
            rem_h_next  = '0;
            rem_m_next  = '0;
            rem_s_next  = '0;
          end else begin
            rem_secs_next = rem_secs - SecsW'(1);
            if (rem_s != '0) begin
              rem_s_next = rem_s - MinSecW'(1);
            end else begin
              rem_s_next = MinSecMax;
              if (rem_m != '0) begin
                rem_m_next = rem_m - MinSecW'(1);
              end else begin
                rem_m_next = MinSecMax;
                rem_h_next = rem_h - HourW'(1);
              end
            end
          end
          disp_h_next = rem_h_next;
          disp_m_next = rem_m_next;
          disp_s_next = rem_s_next;
        end
      end
      KIND_TOGGLE: begin
        if (run) begin
          run_next = 1'b0;
        end else if (!loaded) begin
          // A zero total still runs and clears itself on the next tick.
          rem_secs_next = load_secs;
          rem_h_next    = disp_h;
          rem_m_next    = disp_m;
          rem_s_next    = disp_s;
          loaded_next   = (load_secs != '0);
          run_next      = 1'b1;
        end else begin
          run_next = 1'b1;
        end
      end
      KIND_RESET: begin
        disp_h_next   = '0;
        disp_m_next   = '0;
        disp_s_next   = '0;
        rem_h_next    = '0;
        rem_m_next    = '0;
        rem_s_next    = '0;
        rem_secs_next = '0;
        run_next      = 1'b0;
        loaded_next   = 1'b0;
      end
      KIND_ADJUST: begin
        if (s1_evt.segment == SEG_HOURS) begin
          disp_h_next = wrap_hours(disp_h, s1_evt.step, s1_evt.direction);
        end else if (s1_evt.segment == SEG_MINUTES) begin
          disp_m_next = wrap_minsec(disp_m, s1_evt.step, s1_evt.direction);
        end else if (s1_evt.segment == SEG_SECONDS) begin
          disp_s_next = wrap_minsec(disp_s, s1_evt.step, s1_evt.direction);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_h   <= '0;
      disp_m   <= '0;
      disp_s   <= '0;
      rem_h    <= '0;
      rem_m    <= '0;
      rem_s    <= '0;
      rem_secs <= '0;
      run      <= 1'b0;
      loaded   <= 1'b0;
    end else if (upd) begin
      disp_h   <= disp_h_next;
      disp_m   <= disp_m_next;
      disp_s   <= disp_s_next;
      rem_h    <= rem_h_next;
      rem_m    <= rem_m_next;
      rem_s    <= rem_s_next;
      rem_secs <= rem_secs_next;
      run      <= run_next;
      loaded   <= loaded_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res.hours    <= disp_h_next;
      res.minutes  <= disp_m_next;
      res.seconds  <= disp_s_next;
      res.running  <= run_next;
      res.active   <= loaded_next;
      res.expiring <= loaded_next && (rem_secs_next < threshold);
    end
  end

endmodule

FILE: rtl/core/hms_countdown_timer_unit.sv
// Top level of the hours/minutes/seconds countdown timer.
// A request passes the input register, then the result register; a downstream stall can hold it between them.
// Throughput: one request per cycle while no result is held back downstream.
// While a result waits downstream the input register takes one more request, then stalls.
// Reset (rst, synchronous) clears the timer, the display and both stages,
// and sets the expire threshold to ten seconds.
`timescale 1ns / 1ps

module hms_countdown_timer_unit
  import hms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  output logic               evt_stall,
  input  logic [1:0]         kind,
  input  logic [1:0]         segment,
  input  logic               direction,
  input  logic [StepW-1:0]   step,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [HourW-1:0]   hours,
  output logic [MinSecW-1:0] minutes,
  output logic [MinSecW-1:0] seconds,
  output logic               running,
  output logic               active,
  output logic               expiring,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SecsW-1:0]   cfg_data
);

  logic             advance;
  logic             s1_valid;
  evt_t             s1_evt;
  evt_t             evt_in;
  res_t             res;
  logic [SecsW-1:0] threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThresholdReset;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  assign evt_in.kind      = kind_t'(kind);
  assign evt_in.segment   = segment;
  assign evt_in.direction = direction;
  assign evt_in.step      = step;

  hms_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_in    (evt_in),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_evt    (s1_evt)
  );

  hms_core u_core (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_evt    (s1_evt),
    .threshold (threshold),
    .res_stall (res_stall),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  assign hours    = res.hours;
  assign minutes  = res.minutes;
  assign seconds  = res.seconds;
  assign running  = res.running;
  assign active   = res.active;
  assign expiring = res.expiring;

  // The input side only stalls when a result is held back downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    evt_stall |-> (res_valid && res_stall))
    else $error("input stalled without a held result");

  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (hours < HourW'(24) && minutes < MinSecW'(60) && seconds < MinSecW'(60)))
    else $error("display field out of range");

  a_expiring_active: assert property (@(posedge clk) disable iff (rst)
    (res_valid && expiring) |-> active)
    else $error("expiring raised while no duration is loaded");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!res_valid && !evt_stall))
    else $error("pipeline not empty after reset");

endmodule

FILE: dv/hms_timer_checker.sv
// Checker for the countdown timer: predicts each result from accepted requests and compares.
`timescale 1ns / 1ps

module hms_timer_checker
  import hms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  input  logic               evt_stall,
  input  logic [1:0]         kind,
  input  logic [1:0]         segment,
  input  logic               direction,
  input  logic [StepW-1:0]   step,
  input  logic               res_valid,
  input  logic               res_stall,
  input  logic [HourW-1:0]   hours,
  input  logic [MinSecW-1:0] minutes,
  input  logic [MinSecW-1:0] seconds,
  input  logic               running,
  input  logic               active,
  input  logic               expiring,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [SecsW-1:0]   cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 checked_count
);

  localparam int HourRange   = 24;
  localparam int MinSecRange = 60;
  localparam int MaxReports  = 10;
  localparam logic [SecsW-1:0] ElapsedMax = '1;

  logic [HourW-1:0]   hour_q;
  logic [MinSecW-1:0] minute_q;
  logic [MinSecW-1:0] second_q;
  logic               run_q;
  logic [SecsW-1:0]   duration_q;
  logic [SecsW-1:0]   elapsed_q;
  logic [SecsW-1:0]   threshold_q;

  res_t expected_displays[$];

  initial begin
    fail_count    = 0;
    checked_count = 0;
    pending       = 0;
  end

  function automatic int wrap_field(int v, int amount, logic down, int range);
    int s;
    int w;
    s = amount % range;
    w = v % range;
    return down ? (w + range - s) % range : (w + s) % range;
  endfunction

  task automatic show_time(int t);
    hour_q   = HourW'(t / 3600);
    minute_q = MinSecW'((t % 3600) / 60);
    second_q = MinSecW'(t % 60);
  endtask

  task automatic stop_timer();
    run_q      = 1'b0;
    duration_q = '0;
    elapsed_q  = '0;
  endtask

  // Applies one event to the predicted timer and returns the display it should produce.
  task automatic advance_timer(input evt_t e, output res_t r);
    int   remaining;
    logic loaded;
    case (e.kind)
      KIND_TICK: begin
        if (run_q) begin
          if (elapsed_q < ElapsedMax) elapsed_q = elapsed_q + 1'b1;
          // The tick after the display reached zero finds elapsed past the duration.
          if (duration_q < elapsed_q) begin
            stop_timer();
            show_time(0);
          end else begin
            show_time(int'(duration_q) - int'(elapsed_q));
          end
        end
      end
      KIND_TOGGLE: begin
        if (run_q) begin
          run_q = 1'b0;
        end else if (duration_q == '0) begin
          duration_q = SecsW'(int'(hour_q) * 3600 + int'(minute_q) * 60 + int'(second_q));
          elapsed_q  = '0;
          run_q      = 1'b1;
        end else begin
          run_q = 1'b1;
        end
      end
      KIND_RESET: begin
        stop_timer();
        show_time(0);
      end
      default: begin
        if (e.segment == SEG_HOURS) begin
          hour_q = HourW'(wrap_field(hour_q, e.step, e.direction == DIR_DOWN, HourRange));
        end else if (e.segment == SEG_MINUTES) begin
          minute_q = MinSecW'(wrap_field(minute_q, e.step, e.direction == DIR_DOWN,
                                         MinSecRange));
        end else if (e.segment == SEG_SECONDS) begin
          second_q = MinSecW'(wrap_field(second_q, e.step, e.direction == DIR_DOWN,
                                         MinSecRange));
        end
      end
    endcase
    loaded    = (duration_q != '0);
    remaining = (loaded && duration_q >= elapsed_q) ? int'(duration_q) - int'(elapsed_q) : 0;
    r.hours    = hour_q;
    r.minutes  = minute_q;
    r.seconds  = second_q;
    r.running  = run_q;
    r.active   = loaded;
    r.expiring = loaded && (remaining < int'(threshold_q));
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    evt_t ev;
    if (rst) begin
      hour_q      = '0;
      minute_q    = '0;
      second_q    = '0;
      threshold_q = ThresholdReset;
      stop_timer();
      expected_displays.delete();
    end else begin
      // Results are compared before this edge's request is predicted; a request
      // cannot produce its result at the edge it is accepted.
      if (res_valid && !res_stall) begin
        got = '{hours: hours, minutes: minutes, seconds: seconds,
                running: running, active: active, expiring: expiring};
        checked_count++;
        if (expected_displays.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("[%0t] unexpected result %0d:%0d:%0d run=%b act=%b exp=%b", $realtime,
                     got.hours, got.minutes, got.seconds, got.running, got.active,
                     got.expiring);
        end else begin
          want = expected_displays.pop_front();
          if (got.hours !== want.hours || got.minutes !== want.minutes ||
              got.seconds !== want.seconds || got.running !== want.running ||
              got.active !== want.active || got.expiring !== want.expiring) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("[%0t] mismatch: expected %0d:%0d:%0d r/a/e=%b%b%b, got %0d:%0d:%0d %b%b%b",
                       $realtime, want.hours, want.minutes, want.seconds, want.running,
                       want.active, want.expiring, got.hours, got.minutes, got.seconds,
                       got.running, got.active, got.expiring);
          end
        end
      end
      if (evt_valid && !evt_stall) begin
        ev.kind      = kind_t'(kind);
        ev.segment   = segment;
        ev.direction = direction;
        ev.step      = step;
        advance_timer(ev, want);
        expected_displays.push_back(want);
      end
      if (cfg_valid && cfg_ready) threshold_q = cfg_data;
    end
    pending = expected_displays.size();
  end

endmodule

FILE: dv/tb_hms_countdown_timer_unit.sv
// Top of the countdown timer testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module tb_hms_countdown_timer_unit;
  import hms_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 260;
  localparam int HoldCycles  = 300;
  localparam logic [SecsW-1:0] ThresholdTop = SecsW'(86399);

  logic               clk;
  logic               rst;
  logic               evt_valid;
  logic               evt_stall;
  logic [1:0]         kind;
  logic [1:0]         segment;
  logic               direction;
  logic [StepW-1:0]   step;
  logic               res_valid;
  logic               res_stall;
  logic [HourW-1:0]   hours;
  logic [MinSecW-1:0] minutes;
  logic [MinSecW-1:0] seconds;
  logic               running;
  logic               active;
  logic               expiring;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SecsW-1:0]   cfg_data;

  int fail_count;
  int pending;
  int checked_count;

  int requests_sent;
  int threshold_writes;
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int cycle_count;

  hms_countdown_timer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .kind      (kind),
    .segment   (segment),
    .direction (direction),
    .step      (step),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .hours     (hours),
    .minutes   (minutes),
    .seconds   (seconds),
    .running   (running),
    .active    (active),
    .expiring  (expiring),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  hms_timer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .evt_valid     (evt_valid),
    .evt_stall     (evt_stall),
    .kind          (kind),
    .segment       (segment),
    .direction     (direction),
    .step          (step),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .hours         (hours),
    .minutes       (minutes),
    .seconds       (seconds),
    .running       (running),
    .active        (active),
    .expiring      (expiring),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: a long hold-off takes priority over the random stall mix.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      res_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_evt(input kind_t k, input logic [1:0] seg, input logic dir,
                          input logic [StepW-1:0] amount);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      evt_valid = 1'b0;
      @(negedge clk);
    end
    evt_valid = 1'b1;
    kind      = k;
    segment   = seg;
    direction = dir;
    step      = amount;
    do @(posedge clk); while (evt_stall);
    requests_sent++;
  endtask

  task automatic send_any();
    send_evt(kind_t'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)),
             StepW'($urandom_range(63)));
  endtask

  // Drops the request valid and lets every outstanding result drain.
  task automatic drain();
    @(negedge clk);
    evt_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [SecsW-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    threshold_writes++;
  endtask

  // One countdown: load a short duration, start it, then mostly ticks with
  // pauses, adjustments and stray requests mixed in.
  task automatic run_countdown();
    int n;
    int r;
    if ($urandom_range(99) < 75) send_evt(KIND_RESET, 2'($urandom_range(3)),
                                          1'($urandom_range(1)), StepW'($urandom_range(63)));
    send_evt(KIND_ADJUST, SEG_SECONDS, 1'($urandom_range(1)), StepW'($urandom_range(63)));
    if ($urandom_range(99) < 20)
      send_evt(KIND_ADJUST, SEG_MINUTES, DIR_UP, StepW'($urandom_range(2)));
    if ($urandom_range(99) < 5)
      send_evt(KIND_ADJUST, SEG_HOURS, 1'($urandom_range(1)), StepW'($urandom_range(63)));
    send_evt(KIND_TOGGLE, 2'($urandom_range(3)), 1'($urandom_range(1)),
             StepW'($urandom_range(63)));
    n = $urandom_range(10, 80);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 78)
        send_evt(KIND_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)),
                 StepW'($urandom_range(63)));
      else if (r < 86)
        send_evt(KIND_TOGGLE, 2'($urandom_range(3)), 1'($urandom_range(1)),
                 StepW'($urandom_range(63)));
      else if (r < 93)
        send_evt(KIND_ADJUST, 2'($urandom_range(3)), 1'($urandom_range(1)),
                 StepW'($urandom_range(63)));
      else
        send_any();
    end
  endtask

  initial begin
    int               goal;
    logic [SecsW-1:0] limit_value;
    bit               held;
    rst              = 1'b1;
    evt_valid        = 1'b0;
    kind             = KIND_TICK;
    segment          = SEG_HOURS;
    direction        = DIR_UP;
    step             = '0;
    res_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    requests_sent    = 0;
    threshold_writes = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_left        = 0;
    held             = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with the threshold at its reset value.
    send_evt(KIND_TICK,   SEG_HOURS,   DIR_UP,   6'd0);   // tick while idle
    send_evt(KIND_TOGGLE, SEG_HOURS,   DIR_UP,   6'd0);   // zero total starts
    send_evt(KIND_TICK,   SEG_HOURS,   DIR_UP,   6'd0);   // and clears on this tick
    send_evt(KIND_ADJUST, SEG_HOURS,   DIR_UP,   6'd63);
    send_evt(KIND_ADJUST, SEG_HOURS,   DIR_DOWN, 6'd59);
    send_evt(KIND_ADJUST, SEG_MINUTES, DIR_UP,   6'd63);
    send_evt(KIND_ADJUST, SEG_MINUTES, DIR_DOWN, 6'd0);
    send_evt(KIND_ADJUST, SEG_SECONDS, DIR_UP,   6'd59);
    send_evt(KIND_ADJUST, SEG_NONE,    DIR_UP,   6'd63);  // segment with no meaning
    send_evt(KIND_RESET,  SEG_HOURS,   DIR_UP,   6'd0);
    send_evt(KIND_ADJUST, SEG_SECONDS, DIR_UP,   6'd2);
    send_evt(KIND_TOGGLE, SEG_HOURS,   DIR_UP,   6'd0);
    send_evt(KIND_TICK,   SEG_HOURS,   DIR_UP,   6'd0);
    send_evt(KIND_TOGGLE, SEG_HOURS,   DIR_UP,   6'd0);   // pause
    send_evt(KIND_TICK,   SEG_HOURS,   DIR_UP,   6'd0);   // ignored while paused
    send_evt(KIND_TOGGLE, SEG_HOURS,   DIR_UP,   6'd0);   // resume
    send_evt(KIND_ADJUST, SEG_MINUTES, DIR_DOWN, 6'd1);   // display only while running
    send_evt(KIND_TICK,   SEG_HOURS,   DIR_UP,   6'd0);   // reaches zero
    send_evt(KIND_TICK,   SEG_HOURS,   DIR_UP,   6'd0);   // clears
    send_evt(KIND_ADJUST, SEG_HOURS,   DIR_DOWN, 6'd1);
    send_evt(KIND_ADJUST, SEG_MINUTES, DIR_DOWN, 6'd1);
    send_evt(KIND_ADJUST, SEG_SECONDS, DIR_DOWN, 6'd1);
    send_evt(KIND_TOGGLE, SEG_HOURS,   DIR_UP,   6'd0);   // longest duration
    send_evt(KIND_TICK,   SEG_HOURS,   DIR_UP,   6'd0);
    send_evt(KIND_RESET,  SEG_HOURS,   DIR_UP,   6'd0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin limit_value = ThresholdTop; send_idle_pct = 0;  stall_pct = 0;  end
        1: begin limit_value = '0;           send_idle_pct = 69; stall_pct = 0;  end
        2: begin
          limit_value   = SecsW'($urandom_range(40));
          send_idle_pct = 0;
          stall_pct     = 69;
        end
        default: begin
          limit_value   = SecsW'($urandom_range(86399));
          send_idle_pct = 30;
          stall_pct     = 30;
        end
      endcase
      write_threshold(limit_value);
      goal = requests_sent + PhaseItems;
      while (requests_sent < goal) begin
        run_countdown();
        // Long hold-off on the result side while requests keep coming.
        if (ph == 0 && !held && requests_sent > goal - PhaseItems + 50) begin
          hold_left = HoldCycles;
          held      = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d timer requests and checked %0d results under four stall mixes,",
             requests_sent, checked_count);
    $display("with %0d threshold writes including zero and the full-day maximum.",
             threshold_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/hms_pkg.sv
rtl/core/hms_in_reg.sv
rtl/core/hms_core.sv
rtl/core/hms_countdown_timer_unit.sv
dv/hms_timer_checker.sv
dv/tb_hms_countdown_timer_unit.sv
